/* rtl/gn3d_pkg.sv */
// gn3d_pkg: shared constants, permutation ROM and queue status type for the
// gradient noise block. No dependencies.
package gn3d_pkg;

    localparam int COORD_W     = 32;
    localparam int S_TDATA_W   = 3 * COORD_W;
    localparam int LAT_BITS    = 8;
    localparam int HASH_BITS   = 4;
    localparam int CORNERS     = 8;
    localparam int NOISE_W     = 18;
    localparam int M_TDATA_W   = 24;
    localparam int QUEUE_DEPTH = 4;

    // gradient selection codes
    localparam logic [HASH_BITS-1:0] GRAD_U_FROM_Y = 4'd8;
    localparam logic [HASH_BITS-1:0] GRAD_V_FROM_Y = 4'd4;
    localparam logic [HASH_BITS-1:0] GRAD_V_X_LO   = 4'd12;
    localparam logic [HASH_BITS-1:0] GRAD_V_X_HI   = 4'd14;

    localparam logic [LAT_BITS-1:0] PERM_ROM [256] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

    function automatic logic [LAT_BITS-1:0] perm(input logic [LAT_BITS-1:0] idx);
        return PERM_ROM[idx];
    endfunction

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } gn3d_qstat_t;

endpackage

/* rtl/gradient_noise_3d.sv */
// gradient_noise_3d: improved 3D gradient noise, fixed point, streaming.
// Depends on gn3d_pkg, gn3d_front, gn3d_queue, gn3d_back.
//
//  channel | direction | tdata fields (low bit first)
//  s_      | in        | coord_x[31:0], coord_y[63:32], coord_z[95:64]
//  m_      | out       | noise_value[17:0], zero pad to 24 bits
//
// One point per cycle sustained while m_tready stays high; a point passes the
// hash/fade front (three chained ROM lookups), then the queue, then the lerp back
// (gradients, then a multiply and an add per lerp level).
// A 4-entry queue separates the two halves.
// Synchronous active-low reset clears valid and queue state only.
// m_tready low stalls the back; the front stalls only when the queue fills.
module gradient_noise_3d #(
    parameter int FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // coord_x, coord_y, coord_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // noise_value, pad
);
    import gn3d_pkg::*;

    localparam int ENTRY_W = 6 * FRAC_BITS + 35;

    logic               q_push, q_pop;
    logic [ENTRY_W-1:0] q_din, q_dout;
    gn3d_qstat_t        q_stat;

    gn3d_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_push   (q_push),
        .q_data   (q_din),
        .q_full   (q_stat.full)
    );

    gn3d_queue #(.WIDTH(ENTRY_W)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .pop     (q_pop),
        .dout    (q_dout),
        .stat    (q_stat)
    );

    gn3d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_data   (q_dout),
        .q_empty  (q_stat.empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.push |-> !q_stat.full) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.pop |-> !q_stat.empty) else $error("queue underflow");
    a_full_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty)) else $error("queue status inconsistent");
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:18] == 6'd0)) else $error("output pad not zero");

endmodule

/* rtl/gn3d_front.sv */
// gn3d_front: accepts points, hashes the lattice corners and computes fade curves.
// Depends on gn3d_pkg.
module gn3d_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [gn3d_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                 q_push,
    output logic [6*FRAC_BITS+34:0]              q_data,
    input  logic                                 q_full
);
    import gn3d_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * F;
    localparam int QW   = F + 5;
    localparam int FPW  = 2 * F + 4;
    localparam int HOFS = CORNERS * HASH_BITS;

    logic en;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic [LAT_BITS-1:0] lat_reg [3];
    logic [F-1:0]        t1_reg [3];
    logic [LAT_BITS-1:0] a_reg, b_reg, z2_reg;
    logic [F-1:0]        t2_reg [3];
    logic [F-1:0]        sq_reg [3];
    logic [LAT_BITS-1:0] aa_reg, ab_reg, ba_reg, bb_reg;
    logic [F-1:0]        t3_reg [3];
    logic [F-1:0]        cube_reg [3];
    logic [F+3:0]        q_reg [3];
    logic [HASH_BITS-1:0] h_reg [CORNERS];
    logic [F-1:0]        t4_reg [3];
    logic [F:0]          fade_reg [3];

    logic [PW-1:0]  sq_w [3];
    logic [PW-1:0]  cu_w [3];
    logic [QW-1:0]  q_w [3];
    logic [FPW-1:0] fp_w [3];
    logic [LAT_BITS-1:0] hidx [CORNERS];
    logic [LAT_BITS-1:0] hval [CORNERS];

    assign en       = !v4_reg || !q_full;
    assign s_tready = en;
    assign q_push   = v4_reg && !q_full;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_w[i] = PW'(t1_reg[i]) * PW'(t1_reg[i]);
            cu_w[i] = PW'(sq_reg[i]) * PW'(t2_reg[i]);
            q_w[i]  = QW'(sq_reg[i]) * QW'(6) + (QW'(10) << F) - QW'(t2_reg[i]) * QW'(15);
            fp_w[i] = FPW'(cube_reg[i]) * FPW'(q_reg[i]);
        end
        hidx[0] = aa_reg;
        hidx[1] = ba_reg;
        hidx[2] = ab_reg;
        hidx[3] = bb_reg;
        hidx[4] = aa_reg + 8'd1;
        hidx[5] = ba_reg + 8'd1;
        hidx[6] = ab_reg + 8'd1;
        hidx[7] = bb_reg + 8'd1;
        for (int c = 0; c < CORNERS; c++) begin
            hval[c] = perm(hidx[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                lat_reg[i]  <= s_tdata[i*COORD_W+F +: LAT_BITS];
                t1_reg[i]   <= s_tdata[i*COORD_W +: F];
                t2_reg[i]   <= t1_reg[i];
                sq_reg[i]   <= sq_w[i][PW-1:F];
                t3_reg[i]   <= t2_reg[i];
                cube_reg[i] <= cu_w[i][PW-1:F];
                q_reg[i]    <= q_w[i][F+3:0];
                t4_reg[i]   <= t3_reg[i];
                fade_reg[i] <= fp_w[i][2*F:F];
            end
            a_reg  <= perm(lat_reg[0]) + lat_reg[1];
            b_reg  <= perm(lat_reg[0] + 8'd1) + lat_reg[1];
            z2_reg <= lat_reg[2];
            aa_reg <= perm(a_reg) + z2_reg;
            ab_reg <= perm(a_reg + 8'd1) + z2_reg;
            ba_reg <= perm(b_reg) + z2_reg;
            bb_reg <= perm(b_reg + 8'd1) + z2_reg;
            for (int c = 0; c < CORNERS; c++) begin
                h_reg[c] <= hval[c][HASH_BITS-1:0];
            end
        end
    end

    always_comb begin
        q_data = '0;
        for (int c = 0; c < CORNERS; c++) begin
            q_data[c*HASH_BITS +: HASH_BITS] = h_reg[c];
        end
        for (int i = 0; i < 3; i++) begin
            q_data[HOFS + i*F +: F]                 = t4_reg[i];
            q_data[HOFS + 3*F + i*(F+1) +: (F+1)]  = fade_reg[i];
        end
    end

endmodule

/* rtl/gn3d_queue.sv */
// gn3d_queue: short FIFO between the hash/fade front and the blend back.
// Depends on gn3d_pkg.
module gn3d_queue #(
    parameter int WIDTH = 131
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  logic [WIDTH-1:0]         din,
    input  logic                     pop,
    output logic [WIDTH-1:0]         dout,
    output gn3d_pkg::gn3d_qstat_t    stat
);
    import gn3d_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    assign dout       = mem[rd_ptr_reg];
    assign stat.push  = push;
    assign stat.pop   = pop;
    assign stat.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

/* rtl/gn3d_back.sv */
// gn3d_back: corner gradients, seven lerps and output saturation.
// Depends on gn3d_pkg.
module gn3d_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [6*FRAC_BITS+34:0]      q_data,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gn3d_pkg::M_TDATA_W-1:0] m_tdata
);
    import gn3d_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int G    = F + 2;
    localparam int L    = F + 3;
    localparam int PW   = 2 * F + 6;
    localparam int HOFS = CORNERS * HASH_BITS;
    localparam logic signed [31:0] NOISE_MAX = 32'sd131071;
    localparam logic signed [31:0] NOISE_MIN = -32'sd131072;

    function automatic logic signed [G-1:0] grad(
        input logic [HASH_BITS-1:0] h,
        input logic signed [F:0] x,
        input logic signed [F:0] y,
        input logic signed [F:0] z
    );
        logic signed [G-1:0] u;
        logic signed [G-1:0] v;
        u = (h < GRAD_U_FROM_Y) ? G'(x) : G'(y);
        if (h < GRAD_V_FROM_Y)                         v = G'(y);
        else if (h inside {GRAD_V_X_LO, GRAD_V_X_HI})  v = G'(x);
        else                                           v = G'(z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic signed [PW-1:0] lmul(
        input logic [F:0] f,
        input logic signed [L-1:0] a,
        input logic signed [L-1:0] b
    );
        logic signed [L:0] d;
        d = (L+1)'(b) - (L+1)'(a);
        return PW'($signed({1'b0, f})) * PW'(d);
    endfunction

    function automatic logic signed [L-1:0] ladd(
        input logic signed [L-1:0] a,
        input logic signed [PW-1:0] p
    );
        logic signed [PW-1:0] s;
        s = p >>> F;
        return a + L'(s);
    endfunction

    logic en;
    logic [7:1] v_reg;

    logic signed [G-1:0]  g_reg [CORNERS];
    logic [F:0]           fu1_reg, fv1_reg, fw1_reg;
    logic signed [PW-1:0] p2_reg [4];
    logic signed [L-1:0]  a2_reg [4];
    logic [F:0]           fv2_reg, fw2_reg;
    logic signed [L-1:0]  l3_reg [4];
    logic [F:0]           fv3_reg, fw3_reg;
    logic signed [PW-1:0] p4_reg [2];
    logic signed [L-1:0]  a4_reg [2];
    logic [F:0]           fw4_reg;
    logic signed [L-1:0]  l5_reg [2];
    logic [F:0]           fw5_reg;
    logic signed [PW-1:0] p6_reg;
    logic signed [L-1:0]  a6_reg;
    logic [NOISE_W-1:0]   noise_reg;

    logic signed [F:0]    off [3][2];
    logic signed [G-1:0]  g_w [CORNERS];
    logic signed [L-1:0]  r_w;
    logic signed [31:0]   rx_w;
    logic [NOISE_W-1:0]   noise_next;

    assign en    = !v_reg[7] || m_tready;
    assign q_pop = !q_empty && en;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            off[i][0] = $signed({1'b0, q_data[HOFS + i*F +: F]});
            off[i][1] = $signed({1'b1, q_data[HOFS + i*F +: F]});
        end
        for (int c = 0; c < CORNERS; c++) begin
            g_w[c] = grad(q_data[c*HASH_BITS +: HASH_BITS],
                          off[0][c & 1], off[1][(c >> 1) & 1], off[2][(c >> 2) & 1]);
        end
        r_w  = ladd(a6_reg, p6_reg);
        rx_w = 32'(r_w);
        if (rx_w > NOISE_MAX)      noise_next = NOISE_MAX[NOISE_W-1:0];
        else if (rx_w < NOISE_MIN) noise_next = NOISE_MIN[NOISE_W-1:0];
        else                       noise_next = rx_w[NOISE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[6:1], q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < CORNERS; c++) g_reg[c] <= g_w[c];
            fu1_reg <= q_data[HOFS + 3*F +: (F+1)];
            fv1_reg <= q_data[HOFS + 3*F + (F+1) +: (F+1)];
            fw1_reg <= q_data[HOFS + 3*F + 2*(F+1) +: (F+1)];
            for (int k = 0; k < 4; k++) begin
                p2_reg[k] <= lmul(fu1_reg, L'(g_reg[2*k]), L'(g_reg[2*k+1]));
                a2_reg[k] <= L'(g_reg[2*k]);
                l3_reg[k] <= ladd(a2_reg[k], p2_reg[k]);
            end
            fv2_reg <= fv1_reg;
            fw2_reg <= fw1_reg;
            fv3_reg <= fv2_reg;
            fw3_reg <= fw2_reg;
            for (int k = 0; k < 2; k++) begin
                p4_reg[k] <= lmul(fv3_reg, l3_reg[2*k], l3_reg[2*k+1]);
                a4_reg[k] <= l3_reg[2*k];
                l5_reg[k] <= ladd(a4_reg[k], p4_reg[k]);
            end
            fw4_reg   <= fw3_reg;
            fw5_reg   <= fw4_reg;
            p6_reg    <= lmul(fw5_reg, l5_reg[0], l5_reg[1]);
            a6_reg    <= l5_reg[0];
            noise_reg <= noise_next;
        end
    end

    assign m_tvalid = v_reg[7];
    assign m_tdata  = M_TDATA_W'(noise_reg);

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking testbench for gradient_noise_3d (improved 3D gradient noise).
// Drives points on the s_ stream, predicts each noise value and checks the m_ stream.
// Depends on gn3d_pkg and the gradient_noise_3d RTL.
`timescale 1ns / 1ps

module tb_top;
    import gn3d_pkg::*;

    localparam int FB       = 16;
    localparam int WDOG_MAX = 5000;
    localparam int N_RAND   = 400;
    localparam longint ONE  = 64'sd1 << FB;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    gradient_noise_3d #(.FRAC_BITS(FB)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    logic [17:0] noise_q [$];
    int          mismatches;
    int          wdog;
    bit          stall_free;

    function automatic longint fshift(longint v);
        return v >>> FB;
    endfunction

    function automatic longint fade(longint t);
        longint t2, t3, q;
        t2 = (t * t) >> FB;
        t3 = (t2 * t) >> FB;
        q  = 6 * t2 + 10 * ONE - 15 * t;
        return (t3 * q) >> FB;
    endfunction

    function automatic longint blend(longint f, longint a, longint b);
        return a + fshift(f * (b - a));
    endfunction

    function automatic longint corner_grad(logic [7:0] hv, longint x, longint y, longint z);
        logic [3:0] h;
        longint u, v;
        h = hv[3:0];
        u = (h < GRAD_U_FROM_Y) ? x : y;
        v = (h < GRAD_V_FROM_Y) ? y : ((h == GRAD_V_X_LO || h == GRAD_V_X_HI) ? x : z);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function automatic logic [7:0] pr(int i);
        return PERM_ROM[i & 255];
    endfunction

    function automatic logic [17:0] noise_of(logic [31:0] cx, logic [31:0] cy,
                                             logic [31:0] cz);
        int X, Y, Z, A, AA, AB, B, BA, BB;
        longint x, y, z, x1, y1, z1, u, v, w, r;
        X = cx[FB +: 8]; Y = cy[FB +: 8]; Z = cz[FB +: 8];
        x = cx[FB-1:0]; y = cy[FB-1:0]; z = cz[FB-1:0];
        x1 = x - ONE; y1 = y - ONE; z1 = z - ONE;
        u = fade(x); v = fade(y); w = fade(z);
        A = pr(X) + Y;     AA = pr(A) + Z; AB = pr(A + 1) + Z;
        B = pr(X + 1) + Y; BA = pr(B) + Z; BB = pr(B + 1) + Z;
        r = blend(w,
            blend(v, blend(u, corner_grad(pr(AA), x, y, z), corner_grad(pr(BA), x1, y, z)),
                     blend(u, corner_grad(pr(AB), x, y1, z), corner_grad(pr(BB), x1, y1, z))),
            blend(v, blend(u, corner_grad(pr(AA + 1), x, y, z1),
                              corner_grad(pr(BA + 1), x1, y, z1)),
                     blend(u, corner_grad(pr(AB + 1), x, y1, z1),
                              corner_grad(pr(BB + 1), x1, y1, z1))));
        if (r > 131071) r = 131071;
        if (r < -131072) r = -131072;
        return r[17:0];
    endfunction

    // directed points: x, y, z, typed expectation where obvious (at integer lattice points)
    typedef struct {
        logic [31:0] x, y, z;
        bit          has_exp;
        logic [17:0] exp_val;
    } point_row_t;

    point_row_t pts [14] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 18'h0},
        '{32'h0005_0000, 32'h0011_0000, 32'h00FF_0000, 1'b1, 18'h0},
        '{32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 1'b1, 18'h0},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 18'h0},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 18'h0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 18'h0},
        '{32'h0000_FFFF, 32'h0000_0001, 32'h0000_8000, 1'b0, 18'h0},
        '{32'h00FF_8000, 32'h00FF_4000, 32'h00FF_C000, 1'b0, 18'h0},
        '{32'hFFFF_8000, 32'h0000_8000, 32'hFFFE_4000, 1'b0, 18'h0},
        '{32'h0100_8000, 32'h01FF_8000, 32'hFF00_8000, 1'b0, 18'h0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_5555, 1'b0, 18'h0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_AAAA, 1'b0, 18'h0},
        '{32'h0000_0001, 32'h0000_FFFF, 32'h0000_0001, 1'b0, 18'h0},
        '{32'h8000_FFFF, 32'h7FFF_0001, 32'hC000_3FFF, 1'b0, 18'h0}
    };

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              bit has_exp, logic [17:0] exp_val);
        while (!stall_free && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        noise_q.push_back(has_exp ? exp_val : noise_of(x, y, z));
    endtask

    // result side
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (noise_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: noise=%h", m_tdata[17:0]);
                end else begin
                    logic [17:0] want;
                    want = noise_q.pop_front();
                    if (m_tdata[17:0] !== want || m_tdata[23:18] !== 6'b0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("noise mismatch: exp=%h got=%h", want, m_tdata);
                    end
                end
            end
            m_tready <= stall_free ? 1'b1 : ($urandom_range(99) >= 24);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int tail;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        mismatches = 0;
        wdog       = 0;
        stall_free = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (pts[i])
            send_point(pts[i].x, pts[i].y, pts[i].z, pts[i].has_exp, pts[i].exp_val);

        // drain before the random part
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (noise_q.size() != 0) @(posedge aclk);

        for (int n = 0; n < N_RAND; n++) begin
            logic [31:0] rx, ry, rz;
            stall_free = (n >= 150 && n < 230);
            rx = $urandom(); ry = $urandom(); rz = $urandom();
            if ($urandom_range(3) == 0) begin
                rx[FB-1:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                rz[FB+7:FB] = 8'hFF;
            end
            send_point(rx, ry, rz, 1'b0, 18'h0);
        end
        stall_free = 1'b0;
        s_tvalid <= 1'b0;

        while (noise_q.size() != 0) @(posedge aclk);
        tail = 0;
        while (tail < 30) begin
            @(posedge aclk);
            tail++;
        end
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
